### hdl/bbps_pkg.sv
// ----------------------------------------------------------------------------
// bbps_pkg
// shared types and codes of the bang-bang path sequencer
// ----------------------------------------------------------------------------
package bbps_pkg;

	localparam int CELL_W  = 4;
	localparam int LSTEP_W = 6;
	localparam int ANGLE_W = 14;
	localparam int TOL_W   = 10;
	localparam int PULSE_W = 16;
	localparam int TRIAL_W = 8;
	localparam int CCNT_W  = 5;
	localparam int SCNT_W  = 7;
	localparam int NCELL_W = 7;
	localparam int NSTEP_W = 9;
	localparam int STEPO_W = 6;
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 3;
	localparam int CFGD_W  = 16;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 32;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [CMD_W-1:0] VALVE_LOCK  = 2'd0;
	localparam logic [CMD_W-1:0] VALVE_LEFT  = 2'd1;
	localparam logic [CMD_W-1:0] VALVE_RIGHT = 2'd2;

	localparam logic [IDX_W-1:0] CFG_TOLERANCE  = 3'd0;
	localparam logic [IDX_W-1:0] CFG_PULSE_LEN  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_MAX_TRIALS = 3'd2;
	localparam logic [IDX_W-1:0] CFG_CELL_COUNT = 3'd3;
	localparam logic [IDX_W-1:0] CFG_STEP_COUNT = 3'd4;

	localparam logic [TOL_W-1:0]   TOL_RST    = 10'd16;
	localparam logic [PULSE_W-1:0] PULSE_RST  = 16'd100;
	localparam logic [TRIAL_W-1:0] TRIALS_RST = 8'd10;
	localparam logic [CCNT_W-1:0]  CCNT_RST   = 5'd16;
	localparam logic [SCNT_W-1:0]  SCNT_RST   = 7'd64;

	localparam logic [TRIAL_W-1:0] TRIAL_SAT = 8'd255;

	typedef struct packed {
		logic                      op;
		logic [CELL_W-1:0]         cell_idx;
		logic                      in_round;
		logic                      close;
		logic signed [ANGLE_W-1:0] angle;
	} item_t;

	typedef struct packed {
		logic [TOL_W-1:0]   tol;
		logic [PULSE_W-1:0] pulse;
		logic [TRIAL_W-1:0] max_trials;
		logic [NSTEP_W-1:0] nsteps;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [PULSE_W-1:0] pulse;
		logic               reached;
		logic [STEPO_W-1:0] step;
		logic               done;
	} res_t;

endpackage

### hdl/multi_cell_bang_bang_path_sequencer_unit.sv
// ----------------------------------------------------------------------------
// multi_cell_bang_bang_path_sequencer_unit
// steers hinge cells through a table of target angles, one command per request
// ----------------------------------------------------------------------------
// s_* takes requests: s_tuser 0 loads a target entry, 1 delivers a measured
// angle of one cell; samples of a round come in ascending cell order.
// m_* returns exactly one valve command per request, in request order.
// cfg_wen / cfg_index / cfg_wdata write the five setup registers; the user must
// write them only while no request is in flight, as the block does not check.
// A request first reads the target table; the second stage then forms the
// error, updates the step state and loads the output register.
// One request is taken per cycle while the output does not stall; the sample
// that closes a round holds s_tready low while it waits in the table read
// stage, since the following table read needs the step index that it settles.
// When m_tready is low, one more request is taken into the table read stage,
// then s_tready drops until the output register drains.
// Reset clears step, trial count and done and restores the register defaults;
// the target table is not cleared and must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module multi_cell_bang_bang_path_sequencer_unit #(
	parameter int MAX_CELLS = 16,
	parameter int MAX_STEPS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bbps_pkg::IN_W-1:0]         s_tdata,  // cell_index, load_step, angle
	input  logic                              s_tuser,  // opcode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bbps_pkg::OUT_W-1:0]        m_tdata,  // cell_out, valve_cmd, pulse_ms,
	                                                    // reached, step_now, done_res, pad
	input  logic                              cfg_wen,
	input  logic [bbps_pkg::IDX_W-1:0]        cfg_index,
	input  logic [bbps_pkg::CFGD_W-1:0]       cfg_wdata
);

	localparam int DEPTH = MAX_CELLS * MAX_STEPS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int FAW   = AW + bbps_pkg::CELL_W + bbps_pkg::NSTEP_W;

	logic [bbps_pkg::TOL_W-1:0]   tol_q;
	logic [bbps_pkg::PULSE_W-1:0] pulse_q;
	logic [bbps_pkg::TRIAL_W-1:0] trials_q;
	logic [bbps_pkg::CCNT_W-1:0]  ccnt_q;
	logic [bbps_pkg::SCNT_W-1:0]  scnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= bbps_pkg::TOL_RST;
			pulse_q  <= bbps_pkg::PULSE_RST;
			trials_q <= bbps_pkg::TRIALS_RST;
			ccnt_q   <= bbps_pkg::CCNT_RST;
			scnt_q   <= bbps_pkg::SCNT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				bbps_pkg::CFG_TOLERANCE:  tol_q    <= cfg_wdata[bbps_pkg::TOL_W-1:0];
				bbps_pkg::CFG_PULSE_LEN:  pulse_q  <= cfg_wdata[bbps_pkg::PULSE_W-1:0];
				bbps_pkg::CFG_MAX_TRIALS: trials_q <= cfg_wdata[bbps_pkg::TRIAL_W-1:0];
				bbps_pkg::CFG_CELL_COUNT: ccnt_q   <= cfg_wdata[bbps_pkg::CCNT_W-1:0];
				bbps_pkg::CFG_STEP_COUNT: scnt_q   <= cfg_wdata[bbps_pkg::SCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective counts
	logic [bbps_pkg::NCELL_W-1:0] ncells;
	logic [bbps_pkg::NSTEP_W-1:0] nsteps;
	bbps_pkg::cfg_t               cfg;

	always_comb begin
		if (ccnt_q == '0) begin
			ncells = bbps_pkg::NCELL_W'(1);
		end else if (bbps_pkg::NCELL_W'(ccnt_q) > bbps_pkg::NCELL_W'(MAX_CELLS)) begin
			ncells = bbps_pkg::NCELL_W'(MAX_CELLS);
		end else begin
			ncells = bbps_pkg::NCELL_W'(ccnt_q);
		end
		if (scnt_q == '0) begin
			nsteps = bbps_pkg::NSTEP_W'(1);
		end else if (bbps_pkg::NSTEP_W'(scnt_q) > bbps_pkg::NSTEP_W'(MAX_STEPS)) begin
			nsteps = bbps_pkg::NSTEP_W'(MAX_STEPS);
		end else begin
			nsteps = bbps_pkg::NSTEP_W'(scnt_q);
		end
		cfg.tol        = tol_q;
		cfg.pulse      = pulse_q;
		cfg.max_trials = trials_q;
		cfg.nsteps     = nsteps;
	end

	// request fields
	logic                                in_op;
	logic [bbps_pkg::CELL_W-1:0]         in_cell;
	logic [bbps_pkg::LSTEP_W-1:0]        in_lstep;
	logic signed [bbps_pkg::ANGLE_W-1:0] in_angle;

	assign in_op    = s_tuser;
	assign in_cell  = s_tdata[3:0];
	assign in_lstep = s_tdata[9:4];
	assign in_angle = s_tdata[23:10];

	// handshake and pipeline control
	logic            s1_valid_q, m_valid_q, s1_adv, s_acc;
	bbps_pkg::item_t item_s1;
	bbps_pkg::res_t  res;
	logic [SW-1:0]   step;

	assign s1_adv   = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = (!s1_valid_q || s1_adv) && !(s1_valid_q && item_s1.close);
	assign s_acc    = s_tvalid && s_tready;

	// table address
	logic [FAW-1:0] addr_full;
	logic [AW-1:0]  addr;
	logic           load_ok, tbl_we, tbl_re;

	always_comb begin
		if (in_op == bbps_pkg::OP_LOAD) begin
			addr_full = FAW'(in_cell) * FAW'(MAX_STEPS) + FAW'(in_lstep);
		end else begin
			addr_full = FAW'(in_cell) * FAW'(MAX_STEPS) + FAW'(step);
		end
		addr    = addr_full[AW-1:0];
		load_ok = (FAW'(in_cell) < FAW'(MAX_CELLS)) && (FAW'(in_lstep) < FAW'(MAX_STEPS));
		tbl_we  = s_acc && (in_op == bbps_pkg::OP_LOAD) && load_ok;
		tbl_re  = s_acc && (in_op == bbps_pkg::OP_SAMPLE);
	end

	logic signed [bbps_pkg::ANGLE_W-1:0] target;

	bbps_tbl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.re    (tbl_re),
		.addr  (addr),
		.wdata (in_angle),
		.rdata (target)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.op       <= in_op;
			item_s1.cell_idx <= in_cell;
			item_s1.in_round <= bbps_pkg::NCELL_W'(in_cell) < ncells;
			item_s1.close    <= (in_op == bbps_pkg::OP_SAMPLE)
			                 && (bbps_pkg::NCELL_W'(in_cell) == ncells - 1'b1);
			item_s1.angle    <= in_angle;
		end
	end

	bbps_seq #(
		.SW (SW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_adv),
		.item   (item_s1),
		.target (target),
		.cfg    (cfg),
		.step   (step),
		.res    (res)
	);

	// output register
	logic [bbps_pkg::OUT_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_data_q <= {2'b00, res.done, res.step, res.reached, res.pulse, res.cmd,
			             item_s1.cell_idx};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

### hdl/bbps_tbl.sv
// ----------------------------------------------------------------------------
// bbps_tbl
// target table, one port, synchronous read with registered data
// ----------------------------------------------------------------------------
module bbps_tbl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic                             re,
	input  logic [AW-1:0]                    addr,
	input  logic signed [bbps_pkg::ANGLE_W-1:0] wdata,
	output logic signed [bbps_pkg::ANGLE_W-1:0] rdata
);

	logic signed [bbps_pkg::ANGLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### hdl/bbps_seq.sv
// ----------------------------------------------------------------------------
// bbps_seq
// error check, valve decision and step / trial / done state update
// ----------------------------------------------------------------------------
module bbps_seq #(
	parameter int SW = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  bbps_pkg::item_t                     item,
	input  logic signed [bbps_pkg::ANGLE_W-1:0] target,
	input  bbps_pkg::cfg_t                      cfg,
	output logic [SW-1:0]                       step,
	output bbps_pkg::res_t                      res
);

	logic [SW-1:0]                step_q, step_d;
	logic [bbps_pkg::TRIAL_W-1:0] trial_q, trial_d, trial_inc;
	logic                         all_q, all_d;
	logic                         done_q, done_d;

	logic signed [bbps_pkg::ANGLE_W:0] err;
	logic [bbps_pkg::ANGLE_W:0]        mag;
	logic                              hit, active, live, go, last;
	logic [bbps_pkg::NSTEP_W-1:0]      step_nx;

	always_comb begin
		err       = {target[bbps_pkg::ANGLE_W-1], target}
		          - {item.angle[bbps_pkg::ANGLE_W-1], item.angle};
		mag       = err[bbps_pkg::ANGLE_W] ? (~err + 1'b1) : err;
		hit       = mag <= {{(bbps_pkg::ANGLE_W + 1 - bbps_pkg::TOL_W){1'b0}}, cfg.tol};
		active    = (item.op == bbps_pkg::OP_SAMPLE) && item.in_round;
		live      = active && !done_q;
		trial_inc = (trial_q == bbps_pkg::TRIAL_SAT) ? trial_q : trial_q + 1'b1;
		go        = (all_q && hit) || (trial_inc >= cfg.max_trials);
		step_nx   = bbps_pkg::NSTEP_W'(step_q) + 1'b1;
		last      = step_nx >= cfg.nsteps;

		step_d  = step_q;
		trial_d = trial_q;
		all_d   = all_q;
		done_d  = done_q;

		res.cmd   = bbps_pkg::VALVE_LOCK;
		res.pulse = '0;

		if (live) begin
			if (!hit) begin
				res.cmd   = err[bbps_pkg::ANGLE_W] ? bbps_pkg::VALVE_RIGHT : bbps_pkg::VALVE_LEFT;
				res.pulse = cfg.pulse;
				all_d     = 1'b0;
			end
			if (item.close) begin
				trial_d = trial_inc;
				if (go) begin
					if (last) begin
						done_d = 1'b1;
					end else begin
						step_d  = step_q + 1'b1;
						trial_d = '0;
					end
				end
				all_d = 1'b1;
			end
		end

		res.reached = active && hit;
		res.step    = bbps_pkg::STEPO_W'(step_d);
		res.done    = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			trial_q <= '0;
			all_q   <= 1'b1;
			done_q  <= 1'b0;
		end else if (adv) begin
			step_q  <= step_d;
			trial_q <= trial_d;
			all_q   <= all_d;
			done_q  <= done_d;
		end
	end

	assign step = step_q;

endmodule

### verif/multi_cell_bang_bang_path_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// multi_cell_bang_bang_path_sequencer_unit_tb
// Drives target loads and measured angles into the sequencer and predicts,
// from its own copy of the target table, step, trial and done state, the
// valve command returned for every request. Each command is checked field by
// field, in order, under random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------
module multi_cell_bang_bang_path_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_CELLS     = 16;
	localparam int N_STEPS     = 64;
	localparam int STEP_GUARD  = 55;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic signed [bbps_pkg::ANGLE_W-1:0] ANGLE_MIN = -14'sd1280;
	localparam logic signed [bbps_pkg::ANGLE_W-1:0] ANGLE_MAX = 14'sd4160;

	typedef struct packed {
		logic [bbps_pkg::CELL_W-1:0]  cell_id;
		logic [bbps_pkg::CMD_W-1:0]   valve;
		logic [bbps_pkg::PULSE_W-1:0] pulse_ms;
		logic                         reached;
		logic [bbps_pkg::STEPO_W-1:0] step;
		logic                         done;
	} valve_cmd_t;

	class valve_cmd_scoreboard;
		logic signed [bbps_pkg::ANGLE_W-1:0] targets[N_CELLS*N_STEPS];
		bit                                  loaded[N_CELLS*N_STEPS];
		logic [bbps_pkg::STEPO_W-1:0]        step_idx;
		logic [bbps_pkg::TRIAL_W-1:0]        trials;
		bit                                  all_reached;
		bit                                  done;
		logic [bbps_pkg::TOL_W-1:0]          tol;
		logic [bbps_pkg::PULSE_W-1:0]        pulse_len;
		logic [bbps_pkg::TRIAL_W-1:0]        max_trials;
		logic [bbps_pkg::CCNT_W-1:0]         cell_cnt;
		logic [bbps_pkg::SCNT_W-1:0]         step_cnt;
		valve_cmd_t                          pending_cmds[$];
		int                                  errors;

		function new();
			step_idx    = '0;
			trials      = '0;
			all_reached = 1'b1;
			done        = 1'b0;
			tol         = bbps_pkg::TOL_RST;
			pulse_len   = bbps_pkg::PULSE_RST;
			max_trials  = bbps_pkg::TRIALS_RST;
			cell_cnt    = bbps_pkg::CCNT_RST;
			step_cnt    = bbps_pkg::SCNT_RST;
			errors      = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void write_reg(logic [bbps_pkg::IDX_W-1:0] idx,
				logic [bbps_pkg::CFGD_W-1:0] value);
			case (idx)
				bbps_pkg::CFG_TOLERANCE:  tol        = value[bbps_pkg::TOL_W-1:0];
				bbps_pkg::CFG_PULSE_LEN:  pulse_len  = value[bbps_pkg::PULSE_W-1:0];
				bbps_pkg::CFG_MAX_TRIALS: max_trials = value[bbps_pkg::TRIAL_W-1:0];
				bbps_pkg::CFG_CELL_COUNT: cell_cnt   = value[bbps_pkg::CCNT_W-1:0];
				bbps_pkg::CFG_STEP_COUNT: step_cnt   = value[bbps_pkg::SCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function int cells_in_use();
			if (cell_cnt == 0) return 1;
			return (int'(cell_cnt) > N_CELLS) ? N_CELLS : int'(cell_cnt);
		endfunction

		function int steps_in_use();
			if (step_cnt == 0) return 1;
			return (int'(step_cnt) > N_STEPS) ? N_STEPS : int'(step_cnt);
		endfunction

		function bit is_loaded(logic [bbps_pkg::CELL_W-1:0] cid);
			return loaded[int'(cid)*N_STEPS + int'(step_idx)];
		endfunction

		function int target_now(logic [bbps_pkg::CELL_W-1:0] cid);
			int t;
			t = targets[int'(cid)*N_STEPS + int'(step_idx)];
			return t;
		endfunction

		function int outstanding();
			return pending_cmds.size();
		endfunction

		function void note_request(logic op, logic [bbps_pkg::CELL_W-1:0] cid,
				logic [bbps_pkg::LSTEP_W-1:0] lstep,
				logic signed [bbps_pkg::ANGLE_W-1:0] angle);
			valve_cmd_t  want;
			int          t;
			int          a;
			int          err;
			int          mag;
			int          ncells;
			want         = '0;
			want.cell_id = cid;
			if (op == bbps_pkg::OP_LOAD) begin
				targets[int'(cid)*N_STEPS + int'(lstep)] = angle;
				loaded[int'(cid)*N_STEPS + int'(lstep)]  = 1'b1;
			end else begin
				ncells = cells_in_use();
				if (int'(cid) < ncells) begin
					t = targets[int'(cid)*N_STEPS + int'(step_idx)];
					a = angle;
					err = t - a;
					mag = (err < 0) ? -err : err;
					want.reached = (mag <= int'(tol));
					if (!done) begin
						if (!want.reached) begin
							want.valve    = (err > 0) ? bbps_pkg::VALVE_LEFT
							                          : bbps_pkg::VALVE_RIGHT;
							want.pulse_ms = pulse_len;
							all_reached   = 1'b0;
						end
						if (int'(cid) == ncells - 1) begin
							if (trials < bbps_pkg::TRIAL_SAT) trials = trials + 8'd1;
							if (all_reached || trials >= max_trials) begin
								if (int'(step_idx) + 1 >= steps_in_use()) begin
									done = 1'b1;
								end else begin
									step_idx = step_idx + 6'd1;
									trials   = '0;
								end
							end
							all_reached = 1'b1;
						end
					end
				end
			end
			want.step = step_idx;
			want.done = done;
			pending_cmds.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_command(logic [bbps_pkg::OUT_W-1:0] word);
			valve_cmd_t want;
			if (pending_cmds.size() == 0) begin
				report($sformatf("command %h with no request pending", word));
				return;
			end
			want = pending_cmds.pop_front();
			compare_field("cell_out", 32'(word[3:0]), 32'(want.cell_id));
			compare_field("valve_cmd", 32'(word[5:4]), 32'(want.valve));
			compare_field("pulse_ms", 32'(word[21:6]), 32'(want.pulse_ms));
			compare_field("reached", 32'(word[22]), 32'(want.reached));
			compare_field("step_now", 32'(word[28:23]), 32'(want.step));
			compare_field("done_res", 32'(word[29]), 32'(want.done));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [bbps_pkg::IN_W-1:0]     s_tdata;
	logic                          s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [bbps_pkg::OUT_W-1:0]    m_tdata;
	logic                          cfg_wen;
	logic [bbps_pkg::IDX_W-1:0]    cfg_index;
	logic [bbps_pkg::CFGD_W-1:0]   cfg_wdata;

	valve_cmd_scoreboard  sb;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   holdoff_left;
	int                   sent_count;
	int                   cycle_count;

	multi_cell_bang_bang_path_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multi_cell_bang_bang_path_sequencer_unit verification failed");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				m_tready <= 1'b0;
				holdoff_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_command(m_tdata);
	end

	function automatic logic signed [bbps_pkg::ANGLE_W-1:0] rand_angle();
		return bbps_pkg::ANGLE_W'(int'($urandom_range(5440)) - 1280);
	endfunction

	function automatic logic signed [bbps_pkg::ANGLE_W-1:0] clamp_angle(int a);
		if (a < -1280) a = -1280;
		if (a > 4160) a = 4160;
		return bbps_pkg::ANGLE_W'(a);
	endfunction

	// mostly near the tolerance, some on its edge, some far off
	function automatic int pick_error();
		int t;
		int r;
		t = int'(sb.tol);
		r = int'($urandom_range(9));
		if (r < 5) return int'($urandom_range(2 * t)) - t;
		if (r < 7) return ($urandom_range(1) == 1 ? 1 : -1) * (t + int'($urandom_range(1)));
		return int'($urandom_range(6000)) - 3000;
	endfunction

	task automatic send_request(logic op, logic [bbps_pkg::CELL_W-1:0] cid,
			logic [bbps_pkg::LSTEP_W-1:0] lstep,
			logic signed [bbps_pkg::ANGLE_W-1:0] angle);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {angle, lstep, cid};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, cid, lstep, angle);
		sent_count++;
	endtask

	task automatic ensure_target(logic [bbps_pkg::CELL_W-1:0] cid);
		if (!sb.is_loaded(cid)) send_request(bbps_pkg::OP_LOAD, cid, sb.step_idx, rand_angle());
	endtask

	task automatic sample_cell(logic [bbps_pkg::CELL_W-1:0] cid, int err);
		int meas;
		ensure_target(cid);
		meas = sb.target_now(cid) - err;
		send_request(bbps_pkg::OP_SAMPLE, cid, bbps_pkg::LSTEP_W'($urandom_range(63)),
			clamp_angle(meas));
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [bbps_pkg::IDX_W-1:0] idx, int value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= bbps_pkg::CFGD_W'(value);
		@(negedge clk);
		cfg_wen   <= 1'b0;
		sb.write_reg(idx, bbps_pkg::CFGD_W'(value));
	endtask

	task automatic set_regs(int tol, int pulse, int trials, int cells, int steps);
		write_reg(bbps_pkg::CFG_TOLERANCE, tol);
		write_reg(bbps_pkg::CFG_PULSE_LEN, pulse);
		write_reg(bbps_pkg::CFG_MAX_TRIALS, trials);
		write_reg(bbps_pkg::CFG_CELL_COUNT, cells);
		write_reg(bbps_pkg::CFG_STEP_COUNT, steps);
	endtask

	// ascending rounds with random content, mixed with table refresh and noise
	task automatic run_rounds(int n);
		int                          stop_at;
		int                          ncells;
		logic [bbps_pkg::CELL_W-1:0] cid;
		stop_at = sent_count + n;
		while (sent_count < stop_at) begin
			ncells = sb.cells_in_use();
			case ($urandom_range(9))
				0: send_request(bbps_pkg::OP_LOAD, bbps_pkg::CELL_W'($urandom_range(15)),
						bbps_pkg::LSTEP_W'($urandom_range(63)), rand_angle());
				1: begin
					cid = bbps_pkg::CELL_W'($urandom_range(15));
					if (int'(cid) >= ncells)
						send_request(bbps_pkg::OP_SAMPLE, cid,
							bbps_pkg::LSTEP_W'($urandom_range(63)), rand_angle());
					else if (int'(cid) != ncells - 1 || sb.step_idx < STEP_GUARD)
						sample_cell(cid, pick_error());
				end
				default: begin
					for (int c = 0; c < ncells; c++) begin
						if ($urandom_range(9) == 0) continue;
						if (c == ncells - 1 && sb.step_idx >= STEP_GUARD) continue;
						sample_cell(bbps_pkg::CELL_W'(c), pick_error());
					end
				end
			endcase
		end
	endtask

	initial begin
		int e;
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = bbps_pkg::OP_LOAD;
		cfg_wen       = 1'b0;
		cfg_index     = bbps_pkg::CFG_TOLERANCE;
		cfg_wdata     = '0;
		holdoff_left  = 0;
		sent_count    = 0;
		send_idle_pct = 34;
		recv_idle_pct = 69;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes of angle, tolerance edges, both bags, round close at reset setup
		send_request(bbps_pkg::OP_LOAD, 4'd15, 6'd63, ANGLE_MAX);
		send_request(bbps_pkg::OP_LOAD, 4'd0, 6'd0, ANGLE_MIN);
		send_request(bbps_pkg::OP_LOAD, 4'd1, 6'd0, 14'sd0);
		send_request(bbps_pkg::OP_LOAD, 4'd15, 6'd0, ANGLE_MAX);
		send_request(bbps_pkg::OP_SAMPLE, 4'd0, 6'd63, ANGLE_MIN);
		send_request(bbps_pkg::OP_SAMPLE, 4'd1, 6'd0, -14'sd16);
		send_request(bbps_pkg::OP_SAMPLE, 4'd1, 6'd0, -14'sd17);
		send_request(bbps_pkg::OP_SAMPLE, 4'd1, 6'd21, 14'sd17);
		send_request(bbps_pkg::OP_SAMPLE, 4'd15, 6'd0, ANGLE_MIN);
		send_request(bbps_pkg::OP_SAMPLE, 4'd0, 6'd42, ANGLE_MAX);
		send_request(bbps_pkg::OP_SAMPLE, 4'd15, 6'd63, ANGLE_MAX);
		settle();
		write_reg(bbps_pkg::CFG_CELL_COUNT, 2);
		// out of round, then a fully reached round moves the step on
		send_request(bbps_pkg::OP_SAMPLE, 4'd9, 6'd63, ANGLE_MAX);
		send_request(bbps_pkg::OP_SAMPLE, 4'd0, 6'd0, ANGLE_MIN);
		send_request(bbps_pkg::OP_SAMPLE, 4'd1, 6'd0, 14'sd0);
		send_request(bbps_pkg::OP_LOAD, 4'd2, 6'd1, 14'sd100);

		settle();
		set_regs(int'($urandom_range(80, 20)), 65535, 3, 5, 127);
		run_rounds(100);

		send_idle_pct = 69;
		recv_idle_pct = 34;
		settle();
		set_regs(1023, 0, 0, 31, 64);
		run_rounds(100);

		// one cell, never reached, until the trial limit forces the step on
		settle();
		set_regs(0, int'($urandom_range(65535)), 255, 0, 64);
		repeat (256) begin
			ensure_target(4'd0);
			e = ($urandom_range(1) == 1 ? 1 : -1) * int'($urandom_range(200, 1));
			if (sb.target_now(4'd0) - e < -1280 || sb.target_now(4'd0) - e > 4160) e = -e;
			sample_cell(4'd0, e);
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		settle();
		set_regs(8, int'($urandom_range(65535)), 2, 3, 64);
		@(posedge clk);
		holdoff_left = 120;
		run_rounds(80);

		// walk to the end of the path, then finish it early
		settle();
		set_regs(int'($urandom_range(50)), int'($urandom_range(65535)), 1, 1, 64);
		while (sb.step_idx < 62) sample_cell(4'd0, pick_error());
		settle();
		write_reg(bbps_pkg::CFG_STEP_COUNT, 0);
		sample_cell(4'd0, pick_error());
		sample_cell(4'd0, pick_error());
		sample_cell(4'd0, 0);
		send_request(bbps_pkg::OP_SAMPLE, 4'd15, 6'd63, rand_angle());
		send_request(bbps_pkg::OP_LOAD, 4'd7, 6'd5, rand_angle());
		sample_cell(4'd0, 3000);

		settle();
		repeat (6) @(negedge clk);
		if (sb.errors == 0)
			$display("multi_cell_bang_bang_path_sequencer_unit verification clean");
		else
			$display("multi_cell_bang_bang_path_sequencer_unit verification failed");
		$finish;
	end

endmodule
